// ----- hdl/sbacc_pkg.sv -----
// sbacc_pkg: command types and op codes shared by the scene bounds accumulator.
// Depends on nothing; used by sbacc_front, sbacc_back and scene_bounds_accumulator.
`timescale 1ns / 1ps

package sbacc_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned NUM_VALUE = 6;

   // request op codes
   localparam logic [1:0] OP_LOAD_ROW = 2'd0;
   localparam logic [1:0] OP_BOUNDS   = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   // classified command kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_BOUNDS = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] NUM_ROWS = 2'd3;

   localparam logic signed [VALUE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic [1:0]                    kind;
      logic [1:0]                    row;
      logic [NUM_VALUE-1:0][VALUE_W-1:0] value;
   } cmd_type;

endpackage

// ----- hdl/sbacc_front.sv -----
// sbacc_front: takes request beats, classifies the op and queues the command.
// Depends on sbacc_pkg.
`timescale 1ns / 1ps

module sbacc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [1:0]               req_row_index,
   input  logic signed [31:0]       req_value_0,
   input  logic signed [31:0]       req_value_1,
   input  logic signed [31:0]       req_value_2,
   input  logic signed [31:0]       req_value_3,
   input  logic signed [31:0]       req_value_4,
   input  logic signed [31:0]       req_value_5,
   output logic                     cmd_valid,
   output sbacc_pkg::cmd_type       cmd,
   input  logic                     cmd_deq
);
   import sbacc_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   cmd_type            queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   cmd_type            new_cmd;
   logic               push;
   logic               pop;

   always_comb begin
      new_cmd.row   = req_row_index;
      new_cmd.value = {req_value_5, req_value_4, req_value_3,
                       req_value_2, req_value_1, req_value_0};
      unique case (req_op)
         OP_LOAD_ROW: new_cmd.kind = (req_row_index < NUM_ROWS) ? KIND_LOAD : KIND_NONE;
         OP_BOUNDS:   new_cmd.kind = KIND_BOUNDS;
         OP_CLEAR:    new_cmd.kind = KIND_CLEAR;
         OP_UNUSED:   new_cmd.kind = KIND_NONE;
         default:     new_cmd.kind = KIND_NONE;
      endcase
   end

   assign req_stall = (count_ff == (PTR_W+1)'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_deq && cmd_valid;
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hdl/sbacc_back.sv -----
// sbacc_back: runs queued commands; one box corner per cycle through the matrix unless
// rsp_stall holds it, then saturating sums and the running min/max box. Depends on sbacc_pkg.
`timescale 1ns / 1ps

module sbacc_back #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  sbacc_pkg::cmd_type       cmd,
   output logic                     cmd_deq,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_scene_min_x,
   output logic signed [31:0]       rsp_scene_min_y,
   output logic signed [31:0]       rsp_scene_min_z,
   output logic signed [31:0]       rsp_scene_max_x,
   output logic signed [31:0]       rsp_scene_max_y,
   output logic signed [31:0]       rsp_scene_max_z,
   output logic                     rsp_has_meshes
);
   import sbacc_pkg::*;

   localparam logic signed [63:0] QMAX64 = 64'sd2147483647;
   localparam logic signed [63:0] QMIN64 = -64'sd2147483648;
   localparam logic signed [33:0] QMAX34 = 34'sd2147483647;
   localparam logic signed [33:0] QMIN34 = -34'sd2147483648;
   localparam logic signed [31:0] Q_ONE  = 32'sd1 <<< FRAC_BITS;

   function automatic value_type sat_prod(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      if (s > QMAX64) begin
         sat_prod = Q_MAX;
      end else if (s < QMIN64) begin
         sat_prod = Q_MIN;
      end else begin
         sat_prod = s[31:0];
      end
   endfunction

   logic                   en;
   logic                   issue;
   logic [2:0]             corner_ff, corner_in;
   value_type              mat_ff [12];
   value_type              pt [3];
   logic signed [63:0]     prod_in [9];

   logic                   s1_valid_ff;
   logic [1:0]             s1_kind_ff;
   logic                   s1_last_ff;
   logic signed [63:0]     s1_prod_ff [9];
   value_type              s1_trans_ff [3];

   logic                   s2_valid_ff;
   logic [1:0]             s2_kind_ff;
   logic                   s2_last_ff;
   value_type              s2_pt_ff [3];
   value_type              s2_pt_in [3];
   logic signed [33:0]     sum34 [3];

   value_type              min_ff [3], min_in [3];
   value_type              max_ff [3], max_in [3];
   logic                   seen_ff, seen_in;
   logic                   rsp_valid_ff;
   value_type              rsp_min_ff [3];
   value_type              rsp_max_ff [3];
   logic                   rsp_seen_ff;

   assign en      = !(rsp_valid_ff && rsp_stall);
   assign issue   = en && cmd_valid;
   assign cmd_deq = issue && ((cmd.kind != KIND_BOUNDS) || (corner_ff == 3'd7));
   assign corner_in = (issue && (cmd.kind == KIND_BOUNDS)) ? corner_ff + 3'd1 : corner_ff;

   always_comb begin
      pt[0] = corner_ff[0] ? cmd.value[3] : cmd.value[0];
      pt[1] = corner_ff[1] ? cmd.value[4] : cmd.value[1];
      pt[2] = corner_ff[2] ? cmd.value[5] : cmd.value[2];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = 64'(mat_ff[r*4+c]) * 64'(pt[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum34[r] = 34'(sat_prod(s1_prod_ff[r*3]))
                  + 34'(sat_prod(s1_prod_ff[r*3+1]))
                  + 34'(sat_prod(s1_prod_ff[r*3+2]))
                  + 34'(s1_trans_ff[r]);
         if (sum34[r] > QMAX34) begin
            s2_pt_in[r] = Q_MAX;
         end else if (sum34[r] < QMIN34) begin
            s2_pt_in[r] = Q_MIN;
         end else begin
            s2_pt_in[r] = sum34[r][31:0];
         end
      end
   end

   always_comb begin
      seen_in = seen_ff;
      for (int a = 0; a < 3; a++) begin
         min_in[a] = min_ff[a];
         max_in[a] = max_ff[a];
      end
      if (s2_valid_ff) begin
         case (s2_kind_ff)
            KIND_BOUNDS: begin
               seen_in = 1'b1;
               for (int a = 0; a < 3; a++) begin
                  if (s2_pt_ff[a] < min_ff[a]) min_in[a] = s2_pt_ff[a];
                  if (s2_pt_ff[a] > max_ff[a]) max_in[a] = s2_pt_ff[a];
               end
            end
            KIND_CLEAR: begin
               seen_in = 1'b0;
               for (int a = 0; a < 3; a++) begin
                  min_in[a] = Q_MAX;
                  max_in[a] = Q_MIN;
               end
            end
            default: begin
               seen_in = seen_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         for (int i = 0; i < 12; i++) begin
            mat_ff[i] <= ((i % 5) == 0) ? Q_ONE : '0;
         end
         for (int a = 0; a < 3; a++) begin
            min_ff[a] <= Q_MAX;
            max_ff[a] <= Q_MIN;
         end
      end else begin
         corner_ff <= corner_in;
         if (issue && (cmd.kind == KIND_LOAD)) begin
            for (int r = 0; r < 3; r++) begin
               if (cmd.row == 2'(r)) begin
                  for (int c = 0; c < 4; c++) begin
                     mat_ff[r*4+c] <= cmd.value[c];
                  end
               end
            end
         end
         if (en) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
            seen_ff     <= seen_in;
            for (int a = 0; a < 3; a++) begin
               min_ff[a] <= min_in[a];
               max_ff[a] <= max_in[a];
            end
            rsp_valid_ff <= s2_valid_ff && s2_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff <= cmd.kind;
         s1_last_ff <= cmd_deq;
         for (int i = 0; i < 9; i++) begin
            s1_prod_ff[i] <= prod_in[i];
         end
         for (int r = 0; r < 3; r++) begin
            s1_trans_ff[r] <= mat_ff[r*4+3];
         end
         s2_kind_ff <= s1_kind_ff;
         s2_last_ff <= s1_last_ff;
         for (int r = 0; r < 3; r++) begin
            s2_pt_ff[r] <= s2_pt_in[r];
         end
         if (s2_valid_ff && s2_last_ff) begin
            rsp_seen_ff <= seen_in;
            for (int a = 0; a < 3; a++) begin
               rsp_min_ff[a] <= min_in[a];
               rsp_max_ff[a] <= max_in[a];
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scene_min_x = rsp_min_ff[0];
   assign rsp_scene_min_y = rsp_min_ff[1];
   assign rsp_scene_min_z = rsp_min_ff[2];
   assign rsp_scene_max_x = rsp_max_ff[0];
   assign rsp_scene_max_y = rsp_max_ff[1];
   assign rsp_scene_max_z = rsp_max_ff[2];
   assign rsp_has_meshes  = rsp_seen_ff;

endmodule

// ----- hdl/scene_bounds_accumulator.sv -----
// scene_bounds_accumulator: top level; request queue front end and corner transform back end.
// Depends on sbacc_pkg, sbacc_front, sbacc_back.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | op, row_index, value_0..value_5
//   rsp_     | out       | rsp_valid/rsp_stall  | scene_min/max x,y,z, has_meshes
//
// A bounds beat issues eight box corners in the back end, one corner per cycle unless
// rsp_stall holds it, through nine parallel 32x32 multipliers; load, clear and unused ops issue once.
// The response passes the s1, s2 and response registers after the last corner issues.
// Reset loads the identity matrix and clears the box; rsp_stall freezes the back end
// while the 4-entry command queue keeps taking request beats until it is full.
`timescale 1ns / 1ps

module scene_bounds_accumulator #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [1:0]         req_row_index,
   input  logic signed [31:0] req_value_0,
   input  logic signed [31:0] req_value_1,
   input  logic signed [31:0] req_value_2,
   input  logic signed [31:0] req_value_3,
   input  logic signed [31:0] req_value_4,
   input  logic signed [31:0] req_value_5,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_scene_min_x,
   output logic signed [31:0] rsp_scene_min_y,
   output logic signed [31:0] rsp_scene_min_z,
   output logic signed [31:0] rsp_scene_max_x,
   output logic signed [31:0] rsp_scene_max_y,
   output logic signed [31:0] rsp_scene_max_z,
   output logic               rsp_has_meshes
);
   import sbacc_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_deq;

   sbacc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_row_index (req_row_index),
      .req_value_0   (req_value_0),
      .req_value_1   (req_value_1),
      .req_value_2   (req_value_2),
      .req_value_3   (req_value_3),
      .req_value_4   (req_value_4),
      .req_value_5   (req_value_5),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_deq       (cmd_deq)
   );

   sbacc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_deq         (cmd_deq),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scene_min_x (rsp_scene_min_x),
      .rsp_scene_min_y (rsp_scene_min_y),
      .rsp_scene_min_z (rsp_scene_min_z),
      .rsp_scene_max_x (rsp_scene_max_x),
      .rsp_scene_max_y (rsp_scene_max_y),
      .rsp_scene_max_z (rsp_scene_max_z),
      .rsp_has_meshes  (rsp_has_meshes)
   );

endmodule
